// ===== src/ftrc_pkg.sv =====
// shared constants, register map and divider interface types for the fan ramp controller
package ftrc_pkg;

  // pwm range and window timing
  localparam int PWM_RATE     = 1000;
  localparam int START_DELAY  = 3000;
  localparam int WINDOW_TICKS = 100;

  // field widths
  localparam int LEVEL_W = 10;
  localparam int PCT_W   = 7;
  localparam int DEG_W   = 6;
  localparam int TEMP_W  = 15;
  localparam int TACHO_W = 16;
  localparam int BOOST_W = 3;
  localparam int TICK_W  = 32;
  localparam int XDIFF_W = 13;

  // serial divider sizing: bits processed per division
  localparam int BOOST_BITS = 11;
  localparam int RAMP_BITS  = 20;
  localparam int SCALE_BITS = $clog2(127 * PWM_RATE + 1);
  localparam int NUM_W      = (RAMP_BITS > SCALE_BITS) ? RAMP_BITS : SCALE_BITS;
  localparam int DEN_W      = XDIFF_W;
  localparam int STEP_W     = $clog2(NUM_W + 1);

  // apb register map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [2:0] REG_DUTY_LOW  = 3'd0;
  localparam logic [2:0] REG_DUTY_HIGH = 3'd1;
  localparam logic [2:0] REG_TEMP_LOW  = 3'd2;
  localparam logic [2:0] REG_TEMP_HIGH = 3'd3;
  localparam logic [2:0] REG_TACHO_MIN = 3'd4;
  localparam logic [2:0] REG_BOOST     = 3'd5;

  // boost level codes
  localparam logic [BOOST_W-1:0] BOOST_NONE       = 3'd0;
  localparam logic [BOOST_W-1:0] BOOST_THIRD      = 3'd1;
  localparam logic [BOOST_W-1:0] BOOST_TWO_THIRDS = 3'd2;
  localparam logic [BOOST_W-1:0] BOOST_THIRTEEN   = 3'd3;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== src/fan_temp_ramp_controller.sv =====
// fan temperature ramp controller: ramp target, slewed drive and tacho window check
// results are computed by the bit-serial divider, which runs 11 steps for boost, 20 for the
//   ramp and 17 for pwm scaling
// one request at a time: the next is accepted only once the last result has been registered
// reset: rst synchronous active high, restores register defaults, clears drive,
//   tick count and tacho state and sets the first window after the start-up delay
module fan_temp_ramp_controller
  import ftrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // apb configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // request stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,  // temperature[14:0], tacho_total[30:15], zero[31]
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata   // drive_level[9:0], target_level[19:10],
                                      // window_speed[35:20], tacho_fault[36], zero[39:37]
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_LOW      = 9'b000000010,
    ST_LOWDIV   = 9'b000000100,
    ST_RAMP     = 9'b000001000,
    ST_MUL      = 9'b000010000,
    ST_RAMPDIV  = 9'b000100000,
    ST_SCALE    = 9'b001000000,
    ST_SCALEDIV = 9'b010000000,
    ST_FIN      = 9'b100000000
  } state_t;

  localparam logic [LEVEL_W-1:0] PWM_MAX    = LEVEL_W'(PWM_RATE);
  localparam logic [NUM_W-1:0]   PWM_NUM    = NUM_W'(PWM_RATE);
  localparam logic [SCALE_BITS-1:0] PWM_SCL = SCALE_BITS'(PWM_RATE);
  localparam logic [DEN_W-1:0]   DEN_THREE  = DEN_W'(3);
  localparam logic [DEN_W-1:0]   DEN_FIFTEEN = DEN_W'(15);
  localparam logic [DEN_W-1:0]   DEN_HUNDRED = DEN_W'(100);

  state_t state;

  // configuration registers
  logic [PCT_W-1:0]   duty_low_pct;
  logic [PCT_W-1:0]   duty_high_pct;
  logic [DEG_W-1:0]   temp_low_deg;
  logic [DEG_W-1:0]   temp_high_deg;
  logic [TACHO_W-1:0] tacho_min_pulses;
  logic [BOOST_W-1:0] boost_level;

  // per-tick working registers
  logic signed [TEMP_W-1:0] temp_r;
  logic [TACHO_W-1:0]       tacho_r;
  logic [PCT_W-1:0]         low_pct;
  logic [PCT_W-1:0]         pct;
  logic                     neg;
  logic [PCT_W-1:0]         dy_mag;
  logic [XDIFF_W-1:0]       dx;
  logic [XDIFF_W-1:0]       xspan;
  logic [LEVEL_W-1:0]       target;

  // persistent state
  logic [TICK_W-1:0]  tick_count;
  logic [TICK_W-1:0]  window_deadline;
  logic [LEVEL_W-1:0] drive_value;
  logic [TACHO_W-1:0] last_tacho;
  logic [TACHO_W-1:0] speed_value;
  logic               fault_flag;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // combinational helpers
  logic signed [PCT_W:0]    span;
  logic [PCT_W-1:0]         span_mag;
  logic [BOOST_BITS-1:0]    boost_num;
  logic [XDIFF_W-1:0]       x0;
  logic [XDIFF_W-1:0]       x1;
  logic signed [PCT_W:0]    dy;
  logic [PCT_W-1:0]         q_pct;
  logic [PCT_W+1:0]         low_sum;
  logic [PCT_W+1:0]         ramp_sum;
  logic [TEMP_W-1:0]        dx_full;
  logic [RAMP_BITS-1:0]     ramp_num;
  logic [SCALE_BITS-1:0]    scale_num;
  logic [TICK_W-1:0]        since;
  logic                     window_due;
  logic [TACHO_W-1:0]       delta;
  logic [LEVEL_W-1:0]       drive_next;
  logic                     out_free;

  ftrc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // boost span and ramp edges
  assign span      = $signed({1'b0, duty_high_pct}) - $signed({1'b0, duty_low_pct});
  assign span_mag  = span[PCT_W] ? PCT_W'(-span) : span[PCT_W-1:0];
  assign x0        = XDIFF_W'(temp_low_deg) * 7'd100;
  assign x1        = XDIFF_W'(temp_high_deg) * 7'd100;
  assign dy        = $signed({1'b0, duty_high_pct}) - $signed({1'b0, low_pct});
  assign dx_full   = temp_r - TEMP_W'(x0);
  assign q_pct     = div_rsp.quot[PCT_W-1:0];
  assign ramp_num  = RAMP_BITS'(dy_mag) * dx;
  assign scale_num = SCALE_BITS'(pct) * PWM_SCL;

  // signed correction of the truncated quotients
  assign low_sum  = neg ? ({2'b00, duty_low_pct} - {2'b00, q_pct})
                        : ({2'b00, duty_low_pct} + {2'b00, q_pct});
  assign ramp_sum = neg ? ({2'b00, low_pct} - {2'b00, q_pct})
                        : ({2'b00, low_pct} + {2'b00, q_pct});

  always_comb begin
    unique case (boost_level)
      BOOST_THIRD:      boost_num = BOOST_BITS'(span_mag);
      BOOST_TWO_THIRDS: boost_num = BOOST_BITS'({span_mag, 1'b0});
      default:          boost_num = BOOST_BITS'(span_mag) * 4'd13;
    endcase
  end

  // divider request per phase
  always_comb begin
    div_req = '0;
    unique case (state)
      ST_LOW: begin
        if (boost_level == BOOST_THIRD || boost_level == BOOST_TWO_THIRDS ||
            boost_level == BOOST_THIRTEEN) begin
          div_req.start = 1'b1;
          div_req.num   = {boost_num, (NUM_W - BOOST_BITS)'(0)};
          div_req.den   = (boost_level == BOOST_THIRTEEN) ? DEN_FIFTEEN : DEN_THREE;
          div_req.steps = STEP_W'(BOOST_BITS);
        end
      end
      ST_MUL: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'({ramp_num, (NUM_W - RAMP_BITS + 1)'(0)} >> 1);
        div_req.den   = xspan;
        div_req.steps = STEP_W'(RAMP_BITS);
      end
      ST_SCALE: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'({scale_num, (NUM_W - SCALE_BITS + 1)'(0)} >> 1);
        div_req.den   = DEN_HUNDRED;
        div_req.steps = STEP_W'(SCALE_BITS);
      end
      default: begin
      end
    endcase
  end

  // slew and window bookkeeping
  assign since      = tick_count - window_deadline;
  assign window_due = (since != '0) && !since[TICK_W-1];
  assign delta      = tacho_r - last_tacho;
  assign out_free   = !m_tvalid || m_tready;

  always_comb begin
    drive_next = drive_value;
    if (tick_count[1:0] == 2'b00) begin
      if (drive_value > target) begin
        drive_next = drive_value - 1'b1;
      end else if (drive_value < target && drive_value < PWM_MAX) begin
        drive_next = drive_value + 1'b1;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_LOW;
        end
        ST_LOW: begin
          if (div_req.start) state <= ST_LOWDIV;
          else state <= ST_RAMP;
        end
        ST_LOWDIV: begin
          if (div_rsp.done) state <= ST_RAMP;
        end
        ST_RAMP: begin
          if ($signed(temp_r) <= $signed(TEMP_W'(x0)) ||
              $signed(temp_r) >= $signed(TEMP_W'(x1))) begin
            state <= ST_SCALE;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_RAMPDIV;
        ST_RAMPDIV: begin
          if (div_rsp.done) state <= ST_SCALE;
        end
        ST_SCALE: state <= ST_SCALEDIV;
        ST_SCALEDIV: begin
          if (div_rsp.done) state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ramp datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      temp_r  <= $signed(s_tdata[TEMP_W-1:0]);
      tacho_r <= s_tdata[TEMP_W +: TACHO_W];
    end
    if (state == ST_LOW) begin
      neg <= span[PCT_W];
      if (boost_level == BOOST_NONE) begin
        low_pct <= duty_low_pct;
      end else if (!div_req.start) begin
        low_pct <= duty_high_pct;
      end
    end
    if (state == ST_LOWDIV && div_rsp.done) begin
      low_pct <= low_sum[PCT_W-1:0];
    end
    if (state == ST_RAMP) begin
      neg    <= dy[PCT_W];
      dy_mag <= dy[PCT_W] ? PCT_W'(-dy) : dy[PCT_W-1:0];
      dx     <= dx_full[XDIFF_W-1:0];
      xspan  <= x1 - x0;
      if ($signed(temp_r) <= $signed(TEMP_W'(x0))) begin
        pct <= low_pct;
      end else if ($signed(temp_r) >= $signed(TEMP_W'(x1))) begin
        pct <= duty_high_pct;
      end
    end
    if (state == ST_RAMPDIV && div_rsp.done) begin
      pct <= ramp_sum[PCT_W-1:0];
    end
    if (state == ST_SCALEDIV && div_rsp.done) begin
      target <= (div_rsp.quot > PWM_NUM) ? PWM_MAX : div_rsp.quot[LEVEL_W-1:0];
    end
  end

  // drive, window state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= '0;
      window_deadline <= TICK_W'(START_DELAY);
      drive_value     <= '0;
      last_tacho      <= '0;
      speed_value     <= '0;
      fault_flag      <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        drive_value <= drive_next;
        tick_count  <= tick_count + 1'b1;
        m_tvalid    <= 1'b1;
        if (window_due) begin
          fault_flag      <= (tacho_min_pulses != '0) && (delta <= tacho_min_pulses);
          window_deadline <= tick_count + TICK_W'(WINDOW_TICKS);
          speed_value     <= delta;
          last_tacho      <= tacho_r;
        end
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      m_tdata <= {3'b000,
                  window_due ? ((tacho_min_pulses != '0) && (delta <= tacho_min_pulses))
                             : fault_flag,
                  window_due ? delta : speed_value,
                  target,
                  drive_next};
    end
  end

  assign s_tready = (state == ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_low_pct     <= PCT_W'(20);
      duty_high_pct    <= PCT_W'(95);
      temp_low_deg     <= DEG_W'(30);
      temp_high_deg    <= DEG_W'(40);
      tacho_min_pulses <= TACHO_W'(4);
      boost_level      <= BOOST_NONE;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        REG_DUTY_LOW:  duty_low_pct     <= pwdata[PCT_W-1:0];
        REG_DUTY_HIGH: duty_high_pct    <= pwdata[PCT_W-1:0];
        REG_TEMP_LOW:  temp_low_deg     <= pwdata[DEG_W-1:0];
        REG_TEMP_HIGH: temp_high_deg    <= pwdata[DEG_W-1:0];
        REG_TACHO_MIN: tacho_min_pulses <= pwdata[TACHO_W-1:0];
        REG_BOOST:     boost_level      <= pwdata[BOOST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      REG_DUTY_LOW:  prdata = DATA_W'(duty_low_pct);
      REG_DUTY_HIGH: prdata = DATA_W'(duty_high_pct);
      REG_TEMP_LOW:  prdata = DATA_W'(temp_low_deg);
      REG_TEMP_HIGH: prdata = DATA_W'(temp_high_deg);
      REG_TACHO_MIN: prdata = DATA_W'(tacho_min_pulses);
      REG_BOOST:     prdata = DATA_W'(boost_level);
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // drive stays inside the pwm range
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    drive_value <= PWM_MAX)
    else $error("drive above pwm range");

  // drive moves only on slew ticks and by one step
  a_drive_slew: assert property (@(posedge clk) disable iff (rst)
    !$stable(drive_value) |-> ($past(tick_count[1:0]) == 2'b00) &&
      (drive_value == $past(drive_value) + 1'b1 ||
       drive_value == $past(drive_value) - 1'b1))
    else $error("drive slewed off schedule");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_LOWDIV || state == ST_RAMPDIV || state == ST_SCALEDIV))
    else $error("divider result with no waiting phase");

  // one tick counted per result produced
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    (tick_count != $past(tick_count)) |-> m_tvalid && $past(state == ST_FIN))
    else $error("tick advanced without a result");

endmodule

// ===== src/ftrc_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle, numerator left-aligned
module ftrc_div
  import ftrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] count;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [NUM_W-1:0]  num_sh;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W+1:0]  trial;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {1'b0, rem, num_sh[NUM_W-1]} - {2'b00, den};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= req.steps;
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem    <= '0;
      den    <= req.den;
      num_sh <= req.num;
      quo    <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      quo    <= {quo[NUM_W-2:0], ~trial[DEN_W+1]};
      if (!trial[DEN_W+1]) begin
        rem <= trial[DEN_W-1:0];
      end else begin
        rem <= {rem[DEN_W-2:0], num_sh[NUM_W-1]};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule
